// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the fraction ALU checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== sv/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU package
// Widths, operation codes and shared constants of the fraction ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfa_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int DEN_W      = DATA_WIDTH - 1;
   localparam int WIDE_W     = 2 * DATA_WIDTH;
   localparam int SHIFT_W    = $clog2(WIDE_W + 1);
   localparam int COUNT_W    = $clog2(WIDE_W);
   localparam int RES_NUM_W  = 32;
   localparam int RES_DEN_W  = 31;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_ADD = 2'd0;
   localparam opcode_type OP_SUB = 2'd1;
   localparam opcode_type OP_MUL = 2'd2;
   localparam opcode_type OP_DIV = 2'd3;

   typedef logic [WIDE_W-1:0] wide_type;

endpackage

// ===== sv/rational_fraction_alu.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// Channel   Handshake          Ports
// request   start, busy        req_opcode, req_a_num, req_a_den, req_b_num, req_b_den
// response  rsp_valid strobe   rsp_res_num, rsp_res_den, rsp_div_error
//
// Multiply or divide forms the numerator and denominator products, then one
// binary GCD run and two serial divider runs reduce them. Add or subtract first
// divides each denominator by their GCD, forms three products and the sum, then
// reduces the result the same way. A division by a zero fraction goes straight
// to the finish state and flags an error.
// The result beat is strobed for one cycle as busy falls; nothing stalls it.
// Reset is synchronous and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_fraction_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic signed [rfa_pkg::DATA_WIDTH-1:0] req_a_num,
   input  logic [rfa_pkg::DEN_W-1:0]            req_a_den,
   input  logic signed [rfa_pkg::DATA_WIDTH-1:0] req_b_num,
   input  logic [rfa_pkg::DEN_W-1:0]            req_b_den,
   output logic                                 rsp_valid,
   output logic signed [rfa_pkg::RES_NUM_W-1:0] rsp_res_num,
   output logic [rfa_pkg::RES_DEN_W-1:0]        rsp_res_den,
   output logic                                 rsp_div_error
);
   import rfa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_GCD_D, S_DIV_FA, S_DIV_FB, S_MUL_A, S_MUL_B, S_MUL_D, S_SUM,
      S_MUL_N, S_MUL_R, S_GCD_R, S_DIV_N, S_DIV_D, S_FINISH
   } state_type;

   state_type                 state_ff;
   opcode_type                op_ff;
   logic [DATA_WIDTH-1:0]     amag_ff, bmag_ff;
   logic                      asign_ff, bsign_ff;
   logic [DEN_W-1:0]          ad_ff, bd_ff;
   wide_type                  g_ff, fa_ff, fb_ff, ta_ff, tb_ff, num_ff, den_ff;
   logic                      neg_ff, err_ff;
   logic                      gcd_start_ff, div_start_ff;
   logic                      rsp_valid_ff, rsp_err_ff;
   logic signed [RES_NUM_W-1:0] rsp_num_ff;
   logic [RES_DEN_W-1:0]      rsp_den_ff;

   logic [DATA_WIDTH-1:0]     mul_a, mul_b;
   wide_type                  product;
   wide_type                  gcd_x, gcd_y, gcd_result, div_n, div_d, div_q;
   logic                      gcd_done, div_done;
   logic signed [WIDE_W+1:0]  term_a, term_b, sum;
   logic signed [WIDE_W:0]    signed_num;

   always_comb begin
      mul_a = amag_ff;
      mul_b = DATA_WIDTH'(bd_ff);
      case (state_ff)
         S_MUL_A: begin
            mul_a = amag_ff;
            mul_b = fa_ff[DATA_WIDTH-1:0];
         end
         S_MUL_B: begin
            mul_a = bmag_ff;
            mul_b = fb_ff[DATA_WIDTH-1:0];
         end
         S_MUL_D: begin
            mul_a = fa_ff[DATA_WIDTH-1:0];
            mul_b = DATA_WIDTH'(ad_ff);
         end
         S_MUL_N: begin
            mul_a = amag_ff;
            mul_b = (op_ff == OP_MUL) ? bmag_ff : DATA_WIDTH'(bd_ff);
         end
         S_MUL_R: begin
            mul_a = DATA_WIDTH'(ad_ff);
            mul_b = (op_ff == OP_MUL) ? DATA_WIDTH'(bd_ff) : bmag_ff;
         end
         default: begin
            mul_a = amag_ff;
            mul_b = DATA_WIDTH'(bd_ff);
         end
      endcase
   end

   assign product = mul_a * mul_b;

   assign gcd_x = (state_ff == S_GCD_D) ? WIDE_W'(ad_ff) : num_ff;
   assign gcd_y = (state_ff == S_GCD_D) ? WIDE_W'(bd_ff) : den_ff;

   always_comb begin
      div_n = num_ff;
      case (state_ff)
         S_DIV_FA: div_n = WIDE_W'(bd_ff);
         S_DIV_FB: div_n = WIDE_W'(ad_ff);
         S_DIV_N:  div_n = num_ff;
         S_DIV_D:  div_n = den_ff;
         default:  div_n = num_ff;
      endcase
   end
   assign div_d = g_ff;

   assign term_a = asign_ff ? -$signed({2'b00, ta_ff}) : $signed({2'b00, ta_ff});
   assign term_b = (bsign_ff ^ (op_ff == OP_SUB)) ? -$signed({2'b00, tb_ff})
                                                  : $signed({2'b00, tb_ff});
   assign sum    = term_a + term_b;

   assign signed_num = (neg_ff && num_ff != '0) ? -$signed({1'b0, num_ff})
                                                : $signed({1'b0, num_ff});

   rfa_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start_ff),
      .x      (gcd_x),
      .y      (gcd_y),
      .done   (gcd_done),
      .result (gcd_result)
   );

   rfa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_opcode;
                  asign_ff <= req_a_num[DATA_WIDTH-1];
                  bsign_ff <= req_b_num[DATA_WIDTH-1];
                  amag_ff  <= req_a_num[DATA_WIDTH-1] ? DATA_WIDTH'(-req_a_num)
                                                      : DATA_WIDTH'(req_a_num);
                  bmag_ff  <= req_b_num[DATA_WIDTH-1] ? DATA_WIDTH'(-req_b_num)
                                                      : DATA_WIDTH'(req_b_num);
                  ad_ff    <= (req_a_den == '0) ? DEN_W'(1) : req_a_den;
                  bd_ff    <= (req_b_den == '0) ? DEN_W'(1) : req_b_den;
                  neg_ff   <= req_a_num[DATA_WIDTH-1] ^ req_b_num[DATA_WIDTH-1];
                  err_ff   <= 1'b0;
                  if (req_opcode == OP_DIV && req_b_num == '0) begin
                     err_ff   <= 1'b1;
                     state_ff <= S_FINISH;
                  end else if (req_opcode == OP_ADD || req_opcode == OP_SUB) begin
                     gcd_start_ff <= 1'b1;
                     state_ff     <= S_GCD_D;
                  end else begin
                     state_ff <= S_MUL_N;
                  end
               end
            end
            S_GCD_D: begin
               if (gcd_done) begin
                  g_ff         <= gcd_result;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_FA;
               end
            end
            S_DIV_FA: begin
               if (div_done) begin
                  fa_ff        <= div_q;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_FB;
               end
            end
            S_DIV_FB: begin
               if (div_done) begin
                  fb_ff    <= div_q;
                  state_ff <= S_MUL_A;
               end
            end
            S_MUL_A: begin
               ta_ff    <= product;
               state_ff <= S_MUL_B;
            end
            S_MUL_B: begin
               tb_ff    <= product;
               state_ff <= S_MUL_D;
            end
            S_MUL_D: begin
               den_ff   <= product;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               neg_ff       <= sum < 0;
               num_ff       <= (sum < 0) ? WIDE_W'(-sum) : WIDE_W'(sum);
               gcd_start_ff <= 1'b1;
               state_ff     <= S_GCD_R;
            end
            S_MUL_N: begin
               num_ff   <= product;
               state_ff <= S_MUL_R;
            end
            S_MUL_R: begin
               den_ff       <= product;
               gcd_start_ff <= 1'b1;
               state_ff     <= S_GCD_R;
            end
            S_GCD_R: begin
               if (gcd_done) begin
                  g_ff         <= gcd_result;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_N;
               end
            end
            S_DIV_N: begin
               if (div_done) begin
                  num_ff       <= div_q;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_D;
               end
            end
            S_DIV_D: begin
               if (div_done) begin
                  den_ff   <= div_q;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               rsp_valid_ff <= 1'b1;
               rsp_err_ff   <= err_ff;
               rsp_num_ff   <= err_ff ? '0 : RES_NUM_W'(signed_num);
               rsp_den_ff   <= err_ff ? RES_DEN_W'(1) : RES_DEN_W'(den_ff);
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_num   = rsp_num_ff;
   assign rsp_res_den   = rsp_den_ff;
   assign rsp_div_error = rsp_err_ff;

endmodule

// ===== sv/rfa_gcd.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU GCD unit
// Binary greatest common divisor, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfa_gcd (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rfa_pkg::wide_type x,
   input  rfa_pkg::wide_type y,
   output logic             done,
   output rfa_pkg::wide_type result
);
   import rfa_pkg::*;

   logic                run_ff;
   logic                done_ff;
   wide_type            x_ff;
   wide_type            y_ff;
   wide_type            result_ff;
   logic [SHIFT_W-1:0]  k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!run_ff) begin
            if (start) begin
               x_ff   <= x;
               y_ff   <= y;
               k_ff   <= '0;
               run_ff <= 1'b1;
            end
         end else if (y_ff == '0) begin
            result_ff <= x_ff << k_ff;
            done_ff   <= 1'b1;
            run_ff    <= 1'b0;
         end else if (x_ff == '0) begin
            result_ff <= y_ff << k_ff;
            done_ff   <= 1'b1;
            run_ff    <= 1'b0;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + SHIFT_W'(1);
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== sv/rfa_divider.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfa_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rfa_pkg::wide_type dividend,
   input  rfa_pkg::wide_type divisor,
   output logic             done,
   output rfa_pkg::wide_type quotient
);
   import rfa_pkg::*;

   logic                run_ff;
   logic                done_ff;
   wide_type            quot_ff;
   wide_type            rem_ff;
   wide_type            div_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [WIDE_W:0]     trial;
   logic                fits;

   assign trial = {rem_ff, quot_ff[WIDE_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!run_ff) begin
            if (start) begin
               quot_ff <= dividend;
               div_ff  <= divisor;
               rem_ff  <= '0;
               cnt_ff  <= COUNT_W'(WIDE_W - 1);
               run_ff  <= 1'b1;
            end
         end else begin
            rem_ff  <= fits ? WIDE_W'(trial - {1'b0, div_ff}) : WIDE_W'(trial);
            quot_ff <= {quot_ff[WIDE_W-2:0], fits};
            cnt_ff  <= cnt_ff - COUNT_W'(1);
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/rfa_checker.sv =====
// ----------------------------------------------------------------------------
// Fraction ALU checker
// Port-level assertions on the fraction ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic signed [rfa_pkg::RES_NUM_W-1:0] rsp_res_num,
   input logic [rfa_pkg::RES_DEN_W-1:0]        rsp_res_den,
   input logic                                 rsp_div_error
);
   import rfa_pkg::*;

   logic accepted;
   assign accepted = start && !busy;

   `ASSERT_CLK(a_accept_busy, clock, reset, accepted |=> busy)
   `ASSERT_CLK(a_beat_single, clock, reset, rsp_valid |=> !rsp_valid)
   `ASSERT_CLK(a_beat_after_busy, clock, reset, rsp_valid |-> !busy && $past(busy))
   `ASSERT_CLK(a_den_positive, clock, reset, rsp_valid |-> rsp_res_den != '0)
   `ASSERT_CLK(a_error_zero, clock, reset, rsp_valid && rsp_div_error |-> rsp_res_num == '0 && rsp_res_den == RES_DEN_W'(1))

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (.*);
